// ----- hdl/xeu_pkg.sv -----
// Package for the XML entity unescaper: payload and command types,
// entity tables and queue depth. No dependencies.
`default_nettype none
package xeu_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [7:0]  CHAR_AMP    = 8'h26;

    typedef enum logic [1:0] {
        ENT_LT   = 2'd0,
        ENT_GT   = 2'd1,
        ENT_AMP  = 2'd2,
        ENT_QUOT = 2'd3
    } t_ent;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       string_end;
    } t_out_item;

    // Per-item work: flush_len held bytes of entity ent, then an optional
    // byte, then an optional trailing '&'.
    typedef struct packed {
        t_ent       ent;
        logic [2:0] flush_len;
        logic       byte_vld;
        logic [7:0] byte_val;
        logic       amp_tail;
        logic       str_end;
    } t_cmd;

    function automatic logic [2:0] ent_len(input t_ent e);
        case (e)
            ENT_LT:   ent_len = 3'd4;
            ENT_GT:   ent_len = 3'd4;
            ENT_AMP:  ent_len = 3'd5;
            ENT_QUOT: ent_len = 3'd6;
            default:  ent_len = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] ent_char(input t_ent e);
        case (e)
            ENT_LT:   ent_char = 8'h3C;
            ENT_GT:   ent_char = 8'h3E;
            ENT_AMP:  ent_char = 8'h26;
            ENT_QUOT: ent_char = 8'h22;
            default:  ent_char = 8'h3C;
        endcase
    endfunction

    function automatic logic [7:0] ent_text(input t_ent e, input logic [2:0] idx);
        logic [7:0] r;
        r = 8'h00;
        case (idx)
            3'd0: r = CHAR_AMP;
            3'd1: begin
                case (e)
                    ENT_LT:   r = 8'h6C;
                    ENT_GT:   r = 8'h67;
                    ENT_AMP:  r = 8'h61;
                    ENT_QUOT: r = 8'h71;
                    default:  r = 8'h6C;
                endcase
            end
            3'd2: begin
                case (e)
                    ENT_LT:   r = 8'h74;
                    ENT_GT:   r = 8'h74;
                    ENT_AMP:  r = 8'h6D;
                    ENT_QUOT: r = 8'h75;
                    default:  r = 8'h74;
                endcase
            end
            3'd3: begin
                case (e)
                    ENT_LT:   r = 8'h3B;
                    ENT_GT:   r = 8'h3B;
                    ENT_AMP:  r = 8'h70;
                    ENT_QUOT: r = 8'h6F;
                    default:  r = 8'h3B;
                endcase
            end
            3'd4: begin
                case (e)
                    ENT_AMP:  r = 8'h3B;
                    ENT_QUOT: r = 8'h74;
                    default:  r = 8'h00;
                endcase
            end
            3'd5: begin
                case (e)
                    ENT_QUOT: r = 8'h3B;
                    default:  r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/xeu_front.sv -----
// Front end: tracks the partial entity match and turns each item into
// a command for the back end. Depends on xeu_pkg.
`default_nettype none
module xeu_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_acc,
    input  wire xeu_pkg::t_in_item i_item,
    output xeu_pkg::t_cmd         o_cmd,
    output logic                  o_cmd_vld
);
    import xeu_pkg::*;

    logic [2:0] r_len, n_len;
    logic [3:0] r_cand, n_cand;

    logic [2:0] len_v;
    logic [3:0] cand_v;
    logic [3:0] nxt;
    logic       done;
    t_ent       done_ent;
    t_cmd       cmd;

    function automatic t_ent first_ent(input logic [3:0] c);
        if (c[0])      first_ent = ENT_LT;
        else if (c[1]) first_ent = ENT_GT;
        else if (c[2]) first_ent = ENT_AMP;
        else           first_ent = ENT_QUOT;
    endfunction

    always_comb begin
        len_v    = r_len;
        cand_v   = r_cand;
        if (r_len > 3'd5 || r_cand == 4'd0) begin
            len_v  = 3'd0;
            cand_v = 4'd0;
        end
        nxt      = 4'd0;
        done     = 1'b0;
        done_ent = ENT_LT;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && len_v < ent_len(t_ent'(i))
                && ent_text(t_ent'(i), len_v) == i_item.in_byte) begin
                nxt[i] = 1'b1;
                if (len_v + 3'd1 == ent_len(t_ent'(i))) begin
                    done     = 1'b1;
                    done_ent = t_ent'(i);
                end
            end
        end

        cmd          = '0;
        cmd.str_end  = i_item.in_end;
        n_len        = len_v;
        n_cand       = cand_v;
        if (len_v != 3'd0 && done) begin
            cmd.byte_vld = 1'b1;
            cmd.byte_val = ent_char(done_ent);
            n_len        = 3'd0;
            n_cand       = 4'd0;
        end else if (len_v != 3'd0 && nxt != 4'd0) begin
            if (i_item.in_end) begin
                cmd.ent       = first_ent(nxt);
                cmd.flush_len = len_v + 3'd1;
                n_len         = 3'd0;
                n_cand        = 4'd0;
            end else begin
                n_len  = len_v + 3'd1;
                n_cand = nxt;
            end
        end else begin
            if (len_v != 3'd0) begin
                cmd.ent       = first_ent(cand_v);
                cmd.flush_len = len_v;
            end
            n_len  = 3'd0;
            n_cand = 4'd0;
            if (i_item.in_byte == CHAR_AMP) begin
                if (i_item.in_end) begin
                    cmd.amp_tail = 1'b1;
                end else begin
                    n_len  = 3'd1;
                    n_cand = 4'hF;
                end
            end else begin
                cmd.byte_vld = 1'b1;
                cmd.byte_val = i_item.in_byte;
            end
        end
    end

    assign o_cmd     = cmd;
    assign o_cmd_vld = i_acc && (cmd.flush_len != 3'd0 || cmd.byte_vld || cmd.amp_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= 3'd0;
            r_cand <= 4'd0;
        end else if (i_acc) begin
            r_len  <= n_len;
            r_cand <= n_cand;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/xeu_queue.sv -----
// Command queue between front and back end, small register file.
// Depends on xeu_pkg.
`default_nettype none
module xeu_queue #(
    parameter int unsigned P_DEPTH = xeu_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire xeu_pkg::t_cmd i_wdata,
    output logic               o_full,
    input  wire logic          i_rd,
    output xeu_pkg::t_cmd      o_rdata,
    output logic               o_empty
);
    import xeu_pkg::*;

    localparam int unsigned PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(P_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PW'(P_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == PW'(P_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/xeu_back.sv -----
// Back end: expands the command at the queue head into result items,
// one per pop. Depends on xeu_pkg.
`default_nettype none
module xeu_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xeu_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_rd,
    input  wire logic          i_pop,
    output xeu_pkg::t_out_item o_item
);
    import xeu_pkg::*;

    logic [2:0] r_idx;
    logic [2:0] total;
    logic       last;
    logic       take;

    assign total = i_cmd.flush_len + {2'b00, i_cmd.byte_vld} + {2'b00, i_cmd.amp_tail};
    assign last  = (r_idx + 3'd1 == total);
    assign take  = i_pop && !i_cmd_empty;

    always_comb begin
        if (r_idx < i_cmd.flush_len) begin
            o_item.out_byte = ent_text(i_cmd.ent, r_idx);
        end else if (r_idx == i_cmd.flush_len && i_cmd.byte_vld) begin
            o_item.out_byte = i_cmd.byte_val;
        end else begin
            o_item.out_byte = CHAR_AMP;
        end
        o_item.run_end    = last;
        o_item.string_end = last && i_cmd.str_end;
    end

    assign o_cmd_rd = take && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (take) begin
            r_idx <= last ? 3'd0 : r_idx + 3'd1;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/xml_entity_unescape_top.sv -----
// XML entity unescaper, top level: front end, command queue, back end.
// Throughput: one item per cycle while the command queue is not full; an item
// yields up to six results, one per cycle at the output while pop is held, and
// the command queue absorbs the difference.
// Reset: synchronous, active low; clears match state, queue and expander.
// Depends on xeu_pkg, xeu_front, xeu_queue, xeu_back.
`default_nettype none
module xml_entity_unescape_top #(
    parameter int unsigned P_QUEUE_DEPTH = xeu_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire xeu_pkg::t_in_item i_in_item,
    output logic                   empty,
    input  wire logic              pop,
    output xeu_pkg::t_out_item     o_out_item
);
    import xeu_pkg::*;

    t_cmd fe_cmd, q_cmd;
    logic fe_vld, q_full, q_empty, q_rd, acc;

    assign full  = q_full;
    assign empty = q_empty;
    assign acc   = push && !q_full;

    xeu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_item    (i_in_item),
        .o_cmd     (fe_cmd),
        .o_cmd_vld (fe_vld)
    );

    xeu_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_vld),
        .i_wdata (fe_cmd),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_cmd),
        .o_empty (q_empty)
    );

    xeu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_rd    (q_rd),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule
`default_nettype wire

// ----- verif/tb_xml_entity_unescape_top.sv -----
// Testbench for xml_entity_unescape_top: directed table, then random strings,
// checked item by item against a behavioural unescaper. Depends on xeu_pkg.
`timescale 1ns / 100ps
module tb_xml_entity_unescape_top;
    import xeu_pkg::*;

    localparam int DIR_ROWS       = 26;
    localparam int RANDOM_ITEMS   = 480;
    localparam int PRESSURE_AT    = 100;
    localparam int PRESSURE_HOLD  = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        t_in_item  it;
        logic      typed;
        t_out_item xo;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      push      = 1'b0;
    logic      pop       = 1'b0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    xml_entity_unescape_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    // entity tables, rows in t_ent order
    logic [7:0] ent_txt [4][6] = '{
        '{CHAR_AMP, "l", "t", ";", 8'h00, 8'h00},
        '{CHAR_AMP, "g", "t", ";", 8'h00, 8'h00},
        '{CHAR_AMP, "a", "m", "p", ";",   8'h00},
        '{CHAR_AMP, "q", "u", "o", "t",   ";"}
    };
    int         ent_ln [4] = '{4, 4, 5, 6};
    logic [7:0] ent_ch [4] = '{"<", ">", "&", 8'h22};

    logic [2:0] held_len  = '0;
    logic [3:0] held_cand = '0;

    t_stim_row stim_q[$];
    t_out_item run_q[$];
    t_out_item unescaped_q[$];
    int        acc_idx  = 0;
    int        n_err    = 0;
    int        idle_cnt = 0;
    t_out_item want;
    t_stim_row row;

    function automatic t_stim_row drow(input logic [7:0] b, input logic e);
        drow = '{it: '{b, e}, typed: 1'b0, xo: '0};
    endfunction

    function automatic t_stim_row trow(input logic [7:0] b, input logic e,
                                       input logic [7:0] xb, input logic xs);
        trow = '{it: '{b, e}, typed: 1'b1, xo: '{xb, 1'b1, xs}};
    endfunction

    t_stim_row dir_tab [DIR_ROWS] = '{
        trow(8'h00, 1'b0, 8'h00, 1'b0),
        trow(8'hFF, 1'b1, 8'hFF, 1'b1),
        drow(CHAR_AMP, 1'b0), drow("l", 1'b0), drow("t", 1'b0),
        trow(";", 1'b0, "<", 1'b0),
        drow(CHAR_AMP, 1'b0), drow("g", 1'b0), drow("t", 1'b0),
        trow(";", 1'b1, ">", 1'b1),
        drow(CHAR_AMP, 1'b0), drow("a", 1'b0), drow("m", 1'b0), drow("p", 1'b0),
        trow(";", 1'b0, "&", 1'b0),
        drow(CHAR_AMP, 1'b0), drow("q", 1'b0), drow("u", 1'b0), drow("o", 1'b0),
        drow("t", 1'b0),
        trow(";", 1'b1, 8'h22, 1'b1),
        // held bytes broken by a fresh '&', then flushed at end of string
        drow(CHAR_AMP, 1'b0), drow("q", 1'b0), drow(CHAR_AMP, 1'b1),
        drow(CHAR_AMP, 1'b0), drow("x", 1'b1)
    };

    function automatic t_out_item lit(input logic [7:0] b);
        lit = '{b, 1'b0, 1'b0};
    endfunction

    function automatic void flush_held();
        int e;
        int i;
        e = -1;
        for (i = 3; i >= 0; i--)
            if (held_cand[i]) e = i;
        if (e >= 0 && held_len <= 3'd5)
            for (i = 0; i < int'(held_len); i++) run_q.push_back(lit(ent_txt[e][i]));
        held_len  = '0;
        held_cand = '0;
    endfunction

    function automatic void unescape_predict(input t_in_item it);
        logic [3:0] nxt;
        int         done;
        int         i;
        bit         consumed;
        t_out_item  last;
        run_q.delete();
        consumed = 1'b0;
        if (held_len > 3'd5 || held_cand == 4'd0) begin
            held_len  = '0;
            held_cand = '0;
        end
        if (held_len != 3'd0) begin
            nxt  = '0;
            done = -1;
            for (i = 0; i < 4; i++) begin
                if (held_cand[i] && int'(held_len) < ent_ln[i]
                    && ent_txt[i][held_len] == it.in_byte) begin
                    nxt[i] = 1'b1;
                    if (int'(held_len) + 1 == ent_ln[i]) done = i;
                end
            end
            if (done >= 0) begin
                run_q.push_back(lit(ent_ch[done]));
                held_len  = '0;
                held_cand = '0;
                consumed  = 1'b1;
            end else if (nxt != 4'd0) begin
                held_len  = held_len + 3'd1;
                held_cand = nxt;
                consumed  = 1'b1;
            end else begin
                flush_held();
            end
        end
        if (!consumed) begin
            if (it.in_byte == CHAR_AMP) begin
                held_len  = 3'd1;
                held_cand = 4'hF;
            end else begin
                run_q.push_back(lit(it.in_byte));
            end
        end
        if (it.in_end && held_len != 3'd0) flush_held();
        if (run_q.size() > 0) begin
            last = run_q.pop_back();
            last.run_end = 1'b1;
            if (it.in_end) last.string_end = 1'b1;
            run_q.push_back(last);
        end
    endfunction

    // mostly whole entities and their prefixes, with loose bytes between
    task automatic add_random_string();
        logic [7:0] s[$];
        int         n_pieces;
        int         k;
        int         e;
        int         plen;
        int         j;
        n_pieces = $urandom_range(1, 5);
        repeat (n_pieces) begin
            k = $urandom_range(0, 9);
            e = $urandom_range(0, 3);
            case (k)
                0, 1, 2: begin
                    for (j = 0; j < ent_ln[e]; j++) s.push_back(ent_txt[e][j]);
                end
                3, 4: begin
                    plen = $urandom_range(1, ent_ln[e] - 1);
                    for (j = 0; j < plen; j++) s.push_back(ent_txt[e][j]);
                end
                5: s.push_back(CHAR_AMP);
                8: s.push_back(ent_txt[e][$urandom_range(1, ent_ln[e] - 1)]);
                default: s.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        for (j = 0; j < s.size(); j++) stim_q.push_back(drow(s[j], j == s.size() - 1));
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (unescaped_q.size() == 0) begin
                    $error("out_byte: expected none, actual %h", o_out_item.out_byte);
                    n_err++;
                end else begin
                    want = unescaped_q.pop_front();
                    if (o_out_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, o_out_item.out_byte);
                        n_err++;
                    end
                    if (o_out_item.run_end !== want.run_end) begin
                        $error("run_end: expected %b, actual %b",
                               want.run_end, o_out_item.run_end);
                        n_err++;
                    end
                    if (o_out_item.string_end !== want.string_end) begin
                        $error("string_end: expected %b, actual %b",
                               want.string_end, o_out_item.string_end);
                        n_err++;
                    end
                end
            end
            if (push && !full) begin
                row = stim_q[acc_idx];
                acc_idx++;
                unescape_predict(row.it);
                if (row.typed) begin
                    unescaped_q.push_back(row.xo);
                end else begin
                    foreach (run_q[i]) unescaped_q.push_back(run_q[i]);
                end
            end
            if ((pop && !empty) || (push && !full)) begin
                idle_cnt = 0;
            end else begin
                idle_cnt++;
            end
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side; one long hold-off so the block backs up into its input
    initial begin : rx_side
        int gap;
        int n_rx;
        bit quick;
        n_rx  = 0;
        quick = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_rx % 16 == 0) quick = ($urandom_range(0, 3) == 0);
            if (n_rx == PRESSURE_AT) begin
                pop <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge i_clk);
            end
            gap = quick ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            n_rx++;
        end
    end

    initial begin : tx_side
        int idx;
        int gap;
        bit quick;
        quick = 1'b0;
        for (idx = 0; idx < DIR_ROWS; idx++) stim_q.push_back(dir_tab[idx]);
        while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS) add_random_string();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (idx = 0; idx < stim_q.size(); idx++) begin
            if (idx % 20 == 0) quick = ($urandom_range(0, 3) == 0);
            gap = quick ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push      <= 1'b1;
            i_in_item <= stim_q[idx].it;
            do @(posedge i_clk); while (full);
        end
        push <= 1'b0;
        while (acc_idx < stim_q.size() || unescaped_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/xeu_pkg.sv
hdl/xeu_front.sv
hdl/xeu_queue.sv
hdl/xeu_back.sv
hdl/xml_entity_unescape_top.sv
verif/tb_xml_entity_unescape_top.sv
